FILE: hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define CSL_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Check that a trigger is followed in the next cycle by a consequence.
`define CSL_ASSERT_NEXT(lbl, trig, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) else $error(msg);

`endif

FILE: hdl/csl_pkg.sv
// ----------------------------------------------------------------------------
// csl_pkg
// Types, constants and kind decoding shared by the lexer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package csl_pkg;

   localparam int MAX_TOKEN_LEN = 32;
   localparam int IDX_W = $clog2(MAX_TOKEN_LEN);
   localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);

   localparam logic [5:0] K_IDENT   = 6'd0;
   localparam logic [5:0] K_INT     = 6'd1;
   localparam logic [5:0] K_FLOAT   = 6'd2;
   localparam logic [5:0] K_KW_BASE = 6'd3;
   localparam logic [5:0] K_PLUS    = 6'd13;
   localparam logic [5:0] K_MINUS   = 6'd14;
   localparam logic [5:0] K_STAR    = 6'd15;
   localparam logic [5:0] K_SLASH   = 6'd16;
   localparam logic [5:0] K_PCT     = 6'd17;
   localparam logic [5:0] K_LT      = 6'd18;
   localparam logic [5:0] K_GT      = 6'd19;
   localparam logic [5:0] K_COLON   = 6'd20;
   localparam logic [5:0] K_ASSIGN  = 6'd21;
   localparam logic [5:0] K_SEMI    = 6'd22;
   localparam logic [5:0] K_COMMA   = 6'd23;
   localparam logic [5:0] K_LPAREN  = 6'd24;
   localparam logic [5:0] K_RPAREN  = 6'd25;
   localparam logic [5:0] K_LBRACK  = 6'd26;
   localparam logic [5:0] K_RBRACK  = 6'd27;
   localparam logic [5:0] K_LBRACE  = 6'd28;
   localparam logic [5:0] K_RBRACE  = 6'd29;
   localparam logic [5:0] K_NOT     = 6'd30;
   localparam logic [5:0] K_LE      = 6'd31;
   localparam logic [5:0] K_GE      = 6'd32;
   localparam logic [5:0] K_EQ      = 6'd33;
   localparam logic [5:0] K_NE      = 6'd34;
   localparam logic [5:0] K_AND     = 6'd35;
   localparam logic [5:0] K_OR      = 6'd36;

   localparam int NUM_KW = 10;

   // Keyword text, first character in the low byte.
   localparam logic [63:0] KW_TEXT [NUM_KW] = '{
      64'h0000_0074_736e_6f63, // const
      64'h0000_0000_0074_6e69, // int
      64'h0000_0074_616f_6c66, // float
      64'h0000_0000_0000_6669, // if
      64'h0000_0000_6573_6c65, // else
      64'h0000_0065_6c69_6877, // while
      64'h6575_6e69_746e_6f63, // continue
      64'h0000_006b_6165_7262, // break
      64'h0000_6e72_7574_6572, // return
      64'h0000_0000_6469_6f76  // void
   };
   localparam logic [3:0] KW_LEN [NUM_KW] = '{
      4'd5, 4'd3, 4'd5, 4'd2, 4'd4, 4'd5, 4'd8, 4'd5, 4'd6, 4'd4
   };

   typedef enum logic [2:0] {
      M_EMPTY = 3'd0,
      M_IDENT = 3'd1,
      M_INT   = 3'd2,
      M_FLOAT = 3'd3,
      M_OP    = 3'd4,
      M_LINE  = 3'd5,
      M_BLOCK = 3'd6,
      M_STAR  = 3'd7
   } mode_type;

   typedef logic [7:0] text_type [MAX_TOKEN_LEN];

   // One finished token handed from the front to the back.
   typedef struct packed {
      logic [5:0]       kind;
      logic [LEN_W-1:0] len;
      logic             ovf;
   } tok_type;

   // Kind of a single-character operator.
   function automatic logic [5:0] op1_kind(input logic [7:0] c);
      logic [5:0] k;
      unique case (c)
         "+":     k = K_PLUS;
         "-":     k = K_MINUS;
         "*":     k = K_STAR;
         "/":     k = K_SLASH;
         "%":     k = K_PCT;
         "<":     k = K_LT;
         ">":     k = K_GT;
         ":":     k = K_COLON;
         "=":     k = K_ASSIGN;
         ";":     k = K_SEMI;
         ",":     k = K_COMMA;
         "(":     k = K_LPAREN;
         ")":     k = K_RPAREN;
         "[":     k = K_LBRACK;
         "]":     k = K_RBRACK;
         "{":     k = K_LBRACE;
         "}":     k = K_RBRACE;
         "!":     k = K_NOT;
         default: k = K_OR;
      endcase
      return k;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/csl_front.sv
// ----------------------------------------------------------------------------
// csl_front
// Mode machine and token buffer: classifies each byte and hands finished
// tokens to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module csl_front (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push,
   input  wire logic [7:0]               char_in,
   input  wire logic                     back_busy,
   output logic                          tok_push,
   output csl_pkg::tok_type              tok,
   output csl_pkg::text_type             text
);

   csl_pkg::mode_type                mode_ff, mode_in;
   csl_pkg::text_type                text_ff;
   logic [csl_pkg::LEN_W-1:0]        len_ff, len_in;
   logic                             ovf_ff, ovf_in;
   logic                             wr_en;
   logic [csl_pkg::IDX_W-1:0]        wr_idx;
   logic                             acc, ws, digit, letter, single, join_op;
   logic                             start, put;
   logic [5:0]                       kind;
   logic                             kw_hit;
   logic [5:0]                       kw_kind;

   assign acc    = push && !back_busy;
   assign ws     = (char_in == " ") || (char_in == 8'h09) || (char_in == 8'h0a) ||
                   (char_in == 8'h0d);
   assign digit  = (char_in >= "0") && (char_in <= "9");
   assign letter = ((char_in >= "a") && (char_in <= "z")) ||
                   ((char_in >= "A") && (char_in <= "Z")) || (char_in == "_");
   assign single = (len_ff == csl_pkg::LEN_W'(1));
   assign join_op = single &&
      ((char_in == "=" && (text_ff[0] == "<" || text_ff[0] == ">" ||
                           text_ff[0] == "=" || text_ff[0] == "!")) ||
       (char_in == "&" && text_ff[0] == "&") || (char_in == "|" && text_ff[0] == "|"));

   // Match the held text against the keyword list.
   always_comb begin
      kw_hit  = 1'b0;
      kw_kind = csl_pkg::K_IDENT;
      for (int i = 0; i < csl_pkg::NUM_KW; i++) begin
         logic eq;
         eq = (len_ff == csl_pkg::LEN_W'(csl_pkg::KW_LEN[i]));
         for (int j = 0; j < 8; j++) begin
            if (j < int'(csl_pkg::KW_LEN[i]) && text_ff[j] != csl_pkg::KW_TEXT[i][8*j +: 8])
               eq = 1'b0;
         end
         if (eq && !kw_hit) begin
            kw_hit  = 1'b1;
            kw_kind = csl_pkg::K_KW_BASE + 6'(i);
         end
      end
   end

   // Kind of the token now held.
   always_comb begin
      kind = csl_pkg::K_IDENT;
      unique case (mode_ff)
         csl_pkg::M_INT:   kind = csl_pkg::K_INT;
         csl_pkg::M_FLOAT: kind = csl_pkg::K_FLOAT;
         csl_pkg::M_OP: begin
            if (single) begin
               kind = csl_pkg::op1_kind(text_ff[0]);
            end else if (len_ff == csl_pkg::LEN_W'(2) && text_ff[1] == "=") begin
               unique case (text_ff[0])
                  "<":     kind = csl_pkg::K_LE;
                  ">":     kind = csl_pkg::K_GE;
                  "=":     kind = csl_pkg::K_EQ;
                  "!":     kind = csl_pkg::K_NE;
                  default: kind = csl_pkg::K_OR;
               endcase
            end else if (len_ff == csl_pkg::LEN_W'(2) && text_ff[0] == "&" &&
                         text_ff[1] == "&") begin
               kind = csl_pkg::K_AND;
            end else begin
               kind = csl_pkg::K_OR;
            end
         end
         default: kind = (!ovf_ff && kw_hit) ? kw_kind : csl_pkg::K_IDENT;
      endcase
   end

   // Next mode, emission and buffer update.
   always_comb begin
      mode_in  = mode_ff;
      tok_push = 1'b0;
      start    = 1'b0;
      put      = 1'b0;
      unique case (mode_ff)
         csl_pkg::M_LINE: begin
            if (char_in == 8'h0a || char_in == 8'h0d) mode_in = csl_pkg::M_EMPTY;
         end
         csl_pkg::M_BLOCK: begin
            if (char_in == "*") mode_in = csl_pkg::M_STAR;
         end
         csl_pkg::M_STAR: begin
            if (char_in == "/") mode_in = csl_pkg::M_EMPTY;
            else if (char_in != "*") mode_in = csl_pkg::M_BLOCK;
         end
         default: begin
            if (ws) begin
               if (mode_ff != csl_pkg::M_EMPTY) begin
                  tok_push = 1'b1;
                  mode_in  = csl_pkg::M_EMPTY;
               end
            end else if (digit) begin
               if (mode_ff == csl_pkg::M_EMPTY) begin
                  start = 1'b1; mode_in = csl_pkg::M_INT;
               end else if (mode_ff == csl_pkg::M_OP) begin
                  tok_push = 1'b1; start = 1'b1; mode_in = csl_pkg::M_INT;
               end else begin
                  put = 1'b1;
               end
            end else if (char_in == ".") begin
               if (mode_ff == csl_pkg::M_INT) begin
                  mode_in = csl_pkg::M_FLOAT; put = 1'b1;
               end else begin
                  tok_push = (mode_ff != csl_pkg::M_EMPTY);
                  start = 1'b1; mode_in = csl_pkg::M_FLOAT;
               end
            end else if (letter) begin
               if (mode_ff == csl_pkg::M_EMPTY) begin
                  start = 1'b1; mode_in = csl_pkg::M_IDENT;
               end else if (mode_ff == csl_pkg::M_IDENT || mode_ff == csl_pkg::M_INT) begin
                  put = 1'b1;
               end else if (mode_ff == csl_pkg::M_OP) begin
                  tok_push = 1'b1; start = 1'b1; mode_in = csl_pkg::M_IDENT;
               end
            end else begin
               if (mode_ff == csl_pkg::M_EMPTY) begin
                  start = 1'b1; mode_in = csl_pkg::M_OP;
               end else if (mode_ff == csl_pkg::M_OP && join_op) begin
                  put = 1'b1;
               end else if (mode_ff == csl_pkg::M_OP && single && text_ff[0] == "/" &&
                            char_in == "/") begin
                  mode_in = csl_pkg::M_LINE;
               end else if (mode_ff == csl_pkg::M_OP && single && text_ff[0] == "/" &&
                            char_in == "*") begin
                  mode_in = csl_pkg::M_BLOCK;
               end else begin
                  tok_push = 1'b1; start = 1'b1; mode_in = csl_pkg::M_OP;
               end
            end
         end
      endcase
      // a held token is cleared whenever the block goes back to empty or a comment
      len_in = len_ff;
      ovf_in = ovf_ff;
      wr_en  = 1'b0;
      wr_idx = len_ff[csl_pkg::IDX_W-1:0];
      if (start) begin
         len_in = csl_pkg::LEN_W'(1);
         ovf_in = 1'b0;
         wr_en  = 1'b1;
         wr_idx = '0;
      end else if (put) begin
         if (len_ff < csl_pkg::LEN_W'(csl_pkg::MAX_TOKEN_LEN)) begin
            len_in = len_ff + csl_pkg::LEN_W'(1);
            wr_en  = 1'b1;
         end else begin
            ovf_in = 1'b1;
         end
      end else if (mode_in == csl_pkg::M_EMPTY || mode_in == csl_pkg::M_LINE ||
                   mode_in == csl_pkg::M_BLOCK) begin
         if (mode_ff != csl_pkg::M_BLOCK && mode_ff != csl_pkg::M_STAR) begin
            len_in = '0;
            ovf_in = 1'b0;
         end
      end
      tok_push = tok_push && acc;
   end

   // Hold mode and length state.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= csl_pkg::M_EMPTY;
         len_ff  <= '0;
         ovf_ff  <= 1'b0;
      end else if (acc) begin
         mode_ff <= mode_in;
         len_ff  <= len_in;
         ovf_ff  <= ovf_in;
      end
   end

   // Write one character into the buffer.
   always_ff @(posedge clock) begin
      if (acc && wr_en) text_ff[wr_idx] <= char_in;
   end

   assign tok.kind = kind;
   assign tok.len  = len_ff;
   assign tok.ovf  = ovf_ff;
   assign text     = text_ff;

endmodule

`default_nettype wire

FILE: hdl/csl_back.sv
// ----------------------------------------------------------------------------
// csl_back
// Token slot and drain counter: plays a held token out one character per
// request.
// ----------------------------------------------------------------------------
`default_nettype none

module csl_back (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     tok_push,
   input  wire csl_pkg::tok_type         tok,
   input  wire csl_pkg::text_type        text,
   output logic                          busy,
   input  wire logic                     pop,
   output logic [5:0]                    token_kind,
   output logic [7:0]                    char_value,
   output logic [4:0]                    char_index,
   output logic                          last_char,
   output logic                          truncated
);

   logic                             valid_ff;
   csl_pkg::tok_type                 tok_ff;
   csl_pkg::text_type                text_ff;
   logic [csl_pkg::IDX_W-1:0]        idx_ff;
   logic                             last;

   assign last = ({1'b0, idx_ff} + csl_pkg::LEN_W'(1)) == tok_ff.len;

   // Load a token, advance through it on each request.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else if (valid_ff) begin
         if (pop) begin
            idx_ff <= idx_ff + csl_pkg::IDX_W'(1);
            if (last) valid_ff <= 1'b0;
         end
      end else if (tok_push && tok.len != '0) begin
         valid_ff <= 1'b1;
         idx_ff   <= '0;
      end
   end

   // Capture the token payload.
   always_ff @(posedge clock) begin
      if (!valid_ff && tok_push) begin
         tok_ff  <= tok;
         text_ff <= text;
      end
   end

   assign busy       = valid_ff;
   assign token_kind = tok_ff.kind;
   assign char_value = text_ff[idx_ff];
   assign char_index = 5'(idx_ff);
   assign last_char  = last;
   assign truncated  = tok_ff.ovf;

endmodule

`default_nettype wire

FILE: hdl/c_subset_lexer.sv
// ----------------------------------------------------------------------------
// c_subset_lexer
// Byte-stream lexer for a small C subset with a token drain queue.
// ----------------------------------------------------------------------------
// Usage:
//   Input: one source byte per request on req_char_in, taken when req_push
//   is high and req_full is low.
//   Output: each finished token appears as a run of results, one character
//   per request, with kind, index, last flag and truncation flag. A result
//   is shown while rsp_empty is low and taken when rsp_pop is high.
//   A byte that finishes a token shows its first character the next
//   cycle. Throughput: one byte per cycle while no token is draining;
//   a token of N characters holds req_full high until all N of its
//   characters are popped. The single token slot between the mode
//   machine and the drain counter is why bytes stall while a token drains.
//   Reset: mode returns to empty, the buffer length is cleared, the slot
//   is emptied, and rsp_empty goes high.
//   Stall: when the receiver holds off pop, the slot stays full and
//   req_full stays high; no byte is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module c_subset_lexer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   input  wire logic [7:0]  req_char_in,
   output logic             req_full,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [5:0]       rsp_token_kind,
   output logic [7:0]       rsp_char_value,
   output logic [4:0]       rsp_char_index,
   output logic             rsp_last_char,
   output logic             rsp_truncated
);

   logic                 busy, tok_push;
   csl_pkg::tok_type     tok;
   csl_pkg::text_type    text;

   csl_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .char_in   (req_char_in),
      .back_busy (busy),
      .tok_push  (tok_push),
      .tok       (tok),
      .text      (text)
   );

   csl_back u_back (
      .clock      (clock),
      .reset      (reset),
      .tok_push   (tok_push),
      .tok        (tok),
      .text       (text),
      .busy       (busy),
      .pop        (rsp_pop),
      .token_kind (rsp_token_kind),
      .char_value (rsp_char_value),
      .char_index (rsp_char_index),
      .last_char  (rsp_last_char),
      .truncated  (rsp_truncated)
   );

   assign req_full  = busy;
   assign rsp_empty = !busy;

endmodule

`default_nettype wire

FILE: hdl/csl_checker.sv
// ----------------------------------------------------------------------------
// csl_checker
// Port-level checks on the lexer's request and result queues.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module csl_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_full,
   input wire logic        rsp_empty,
   input wire logic        rsp_pop,
   input wire logic [4:0]  rsp_char_index,
   input wire logic        rsp_last_char
);

   // The input side only stalls while a token drains.
   `CSL_ASSERT_ALWAYS(a_full_while_draining, req_full == !rsp_empty, "full without pending token")

   // A token starts at index zero.
   `CSL_ASSERT_NEXT(a_start_zero, rsp_empty, rsp_empty || rsp_char_index == 5'd0, "run not at zero")

   // Indexes advance by one within a run.
   `CSL_ASSERT_NEXT(a_index_step, !rsp_empty && rsp_pop && !rsp_last_char, !rsp_empty && rsp_char_index == $past(rsp_char_index) + 5'd1, "index skipped")

   // The last character ends the run.
   `CSL_ASSERT_NEXT(a_last_ends, !rsp_empty && rsp_pop && rsp_last_char, rsp_empty, "run continued after last")

endmodule

bind c_subset_lexer csl_checker u_csl_checker (
   .clock          (clock),
   .reset          (reset),
   .req_full       (req_full),
   .rsp_empty      (rsp_empty),
   .rsp_pop        (rsp_pop),
   .rsp_char_index (rsp_char_index),
   .rsp_last_char  (rsp_last_char)
);

`default_nettype wire
